@@ src/srtr_pkg.sv @@
// Shared types, constants and the 5x7 font table for the scaled text renderer.
package srtr_pkg;

  localparam int GLYPH_W     = 5;
  localparam int GLYPH_H     = 7;
  localparam int GLYPH_GAP   = 1;
  localparam int MASK_W      = 20;
  localparam int SCALE_W     = 4;
  localparam int COORD_W     = 12;
  localparam int ROW_Y_W     = 13;
  localparam int COLOR_W     = 16;
  localparam int CODE_W      = 8;
  localparam int CFG_W       = 3;
  localparam int IN_DATA_W   = 48;
  localparam int OUT_DATA_W  = 64;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CFG_W-1:0]   SCALE_RESET = 3'd2;
  localparam logic [COORD_W-1:0] CURSOR_MAX  = 12'sd2047;
  localparam logic [2:0]         LAST_FROW   = 3'(GLYPH_H - 1);

  localparam logic [CODE_W-1:0] CHAR_LOWER_A = 8'h61;
  localparam logic [CODE_W-1:0] CHAR_LOWER_Z = 8'h7A;
  localparam logic [CODE_W-1:0] CASE_OFFSET  = 8'h20;

  // Glyph rows, top row first; bit 4 is the leftmost pixel.
  typedef logic [0:GLYPH_H-1][GLYPH_W-1:0] glyph_t;

  // One character ready to be drawn.
  typedef struct packed {
    logic signed [COORD_W-1:0] cursor_x;
    logic signed [COORD_W-1:0] cursor_y;
    glyph_t                    glyph;
    logic [MASK_W-1:0]         col_clip;
    logic [COLOR_W-1:0]        panel_color;
    logic [SCALE_W-1:0]        scale;
  } glyph_job_t;

  function automatic glyph_t glyph_rows(input logic [CODE_W-1:0] code_raw);
    logic [CODE_W-1:0] code;
    glyph_t            g;
    code = code_raw;
    if (code_raw >= CHAR_LOWER_A && code_raw <= CHAR_LOWER_Z) begin
      code = code_raw - CASE_OFFSET;
    end
    case (code)
      8'h21: g = {5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h00, 5'h04}; // !
      8'h22: g = {5'h0A, 5'h0A, 5'h0A, 5'h00, 5'h00, 5'h00, 5'h00}; // "
      8'h23: g = {5'h0A, 5'h0A, 5'h1F, 5'h0A, 5'h1F, 5'h0A, 5'h0A}; // #
      8'h25: g = {5'h19, 5'h19, 5'h02, 5'h04, 5'h08, 5'h13, 5'h13}; // %
      8'h26: g = {5'h0C, 5'h12, 5'h14, 5'h08, 5'h15, 5'h12, 5'h0D}; // &
      8'h27: g = {5'h04, 5'h04, 5'h08, 5'h00, 5'h00, 5'h00, 5'h00}; // '
      8'h28: g = {5'h02, 5'h04, 5'h08, 5'h08, 5'h08, 5'h04, 5'h02}; // (
      8'h29: g = {5'h08, 5'h04, 5'h02, 5'h02, 5'h02, 5'h04, 5'h08}; // )
      8'h2A: g = {5'h00, 5'h15, 5'h0E, 5'h1F, 5'h0E, 5'h15, 5'h00}; // *
      8'h2B: g = {5'h00, 5'h04, 5'h04, 5'h1F, 5'h04, 5'h04, 5'h00}; // +
      8'h2C: g = {5'h00, 5'h00, 5'h00, 5'h00, 5'h06, 5'h04, 5'h08}; // ,
      8'h2D: g = {5'h00, 5'h00, 5'h00, 5'h1F, 5'h00, 5'h00, 5'h00}; // -
      8'h2E: g = {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h0C, 5'h0C}; // .
      8'h2F: g = {5'h01, 5'h02, 5'h02, 5'h04, 5'h08, 5'h08, 5'h10}; // /
      8'h30: g = {5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E}; // 0
      8'h31: g = {5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E}; // 1
      8'h32: g = {5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F}; // 2
      8'h33: g = {5'h1E, 5'h01, 5'h01, 5'h0E, 5'h01, 5'h01, 5'h1E}; // 3
      8'h34: g = {5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02}; // 4
      8'h35: g = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h1E}; // 5
      8'h36: g = {5'h0E, 5'h10, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E}; // 6
      8'h37: g = {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08}; // 7
      8'h38: g = {5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E}; // 8
      8'h39: g = {5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h01, 5'h0E}; // 9
      8'h3A: g = {5'h00, 5'h0C, 5'h0C, 5'h00, 5'h0C, 5'h0C, 5'h00}; // :
      8'h3B: g = {5'h00, 5'h0C, 5'h0C, 5'h00, 5'h06, 5'h04, 5'h08}; // ;
      8'h3F: g = {5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h00, 5'h04}; // ?
      8'h3E: g = {5'h10, 5'h08, 5'h04, 5'h02, 5'h04, 5'h08, 5'h10}; // >
      8'h41: g = {5'h0E, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11}; // A
      8'h42: g = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h11, 5'h11, 5'h1E}; // B
      8'h43: g = {5'h0E, 5'h11, 5'h10, 5'h10, 5'h10, 5'h11, 5'h0E}; // C
      8'h44: g = {5'h1E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1E}; // D
      8'h45: g = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F}; // E
      8'h46: g = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h10}; // F
      8'h47: g = {5'h0E, 5'h11, 5'h10, 5'h17, 5'h11, 5'h11, 5'h0F}; // G
      8'h48: g = {5'h11, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11}; // H
      8'h49: g = {5'h0E, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E}; // I
      8'h4A: g = {5'h07, 5'h02, 5'h02, 5'h02, 5'h12, 5'h12, 5'h0C}; // J
      8'h4B: g = {5'h11, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12, 5'h11}; // K
      8'h4C: g = {5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F}; // L
      8'h4D: g = {5'h11, 5'h1B, 5'h15, 5'h15, 5'h11, 5'h11, 5'h11}; // M
      8'h4E: g = {5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11, 5'h11}; // N
      8'h4F: g = {5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E}; // O
      8'h50: g = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h10}; // P
      8'h51: g = {5'h0E, 5'h11, 5'h11, 5'h11, 5'h15, 5'h12, 5'h0D}; // Q
      8'h52: g = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h14, 5'h12, 5'h11}; // R
      8'h53: g = {5'h0F, 5'h10, 5'h10, 5'h0E, 5'h01, 5'h01, 5'h1E}; // S
      8'h54: g = {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04}; // T
      8'h55: g = {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E}; // U
      8'h56: g = {5'h11, 5'h11, 5'h11, 5'h11, 5'h0A, 5'h0A, 5'h04}; // V
      8'h57: g = {5'h11, 5'h11, 5'h11, 5'h15, 5'h15, 5'h1B, 5'h11}; // W
      8'h58: g = {5'h11, 5'h0A, 5'h04, 5'h04, 5'h04, 5'h0A, 5'h11}; // X
      8'h59: g = {5'h11, 5'h0A, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04}; // Y
      8'h5A: g = {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h1F}; // Z
      8'h5F: g = {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h1F}; // _
      default: g = '0; // space and every code without a glyph
    endcase
    return g;
  endfunction

endpackage

@@ src/scaled_5x7_text_renderer_top.sv @@
// Top level of the scaled 5x7 text renderer.
//
//  channel        dir  handshake                    content
//  s_axis         in   s_axis_tvalid/s_axis_tready  one character per transaction
//  m_axis         out  m_axis_tvalid/m_axis_tready  one row span per transaction
//  cfg            in   cfg_valid_i/cfg_ready_o      glyph_scale write, always ready
//
// A character gives 7*scale spans, one per cycle while m_axis_tready allows, so the
// row walk in the back end sets the rate. A character is registered in the queue and
// its first span in the output register before that span is offered on m_axis.
// Reset clears the cursor to (0,0), sets scale to 2 and empties the queue.
// The two-entry queue lets the front take new characters while the back end is
// stalled by m_axis_tready; a stalled span holds in the output register.
module scaled_5x7_text_renderer_top import srtr_pkg::*; #(
  parameter int FRAME_WIDTH  = 536,
  parameter int FRAME_HEIGHT = 240,
  parameter int MAX_SCALE    = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_W-1:0]      cfg_data_i,     // glyph_scale
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // char_code[7:0], origin_x[19:8], origin_y[31:20], text_color[47:32]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  input  logic                  s_axis_tuser,   // first_char
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // row_y[12:0], span_x[24:13], pixel_mask[44:25], panel_color[60:45], zero[63:61]
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  output logic                  m_axis_tlast    // last_row
);

  glyph_job_t front_job, head_job;
  logic       front_valid, queue_ready, head_valid, head_pop;

  assign cfg_ready_o = 1'b1;

  srtr_front #(
    .FRAME_WIDTH (FRAME_WIDTH),
    .MAX_SCALE   (MAX_SCALE)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i && cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_data_i   (s_axis_tdata),
    .in_first_i  (s_axis_tuser),
    .job_valid_o (front_valid),
    .job_ready_i (queue_ready),
    .job_o       (front_job)
  );

  srtr_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_valid),
    .push_ready_o (queue_ready),
    .push_data_i  (front_job),
    .pop_valid_o  (head_valid),
    .pop_i        (head_pop),
    .pop_data_o   (head_job)
  );

  srtr_back #(
    .FRAME_HEIGHT (FRAME_HEIGHT),
    .MAX_SCALE    (MAX_SCALE)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (head_valid),
    .job_pop_o   (head_pop),
    .job_i       (head_job),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule

@@ src/srtr_front.sv @@
// Front end: takes characters, tracks the cursor, looks up glyphs and column clipping.
module srtr_front import srtr_pkg::*; #(
  parameter int FRAME_WIDTH = 536,
  parameter int MAX_SCALE   = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [IN_DATA_W-1:0] in_data_i,
  input  logic                 in_first_i,
  output logic                 job_valid_o,
  input  logic                 job_ready_i,
  output glyph_job_t           job_o
);

  logic [CFG_W-1:0]          scale_cfg_q;
  logic signed [COORD_W-1:0] cursor_x_q, cursor_x_d;
  logic signed [COORD_W-1:0] cursor_y_q, cursor_y_d;

  logic                        accept;
  logic [CODE_W-1:0]           code;
  logic signed [COORD_W-1:0]   origin_x, origin_y, cur_x, cur_y;
  logic [COLOR_W-1:0]          color;
  logic [SCALE_W-1:0]          scale;
  logic signed [ROW_Y_W-1:0]   next_x;
  logic [MASK_W-1:0]           col_clip;

  assign accept      = in_valid_i && in_ready_o;
  assign in_ready_o  = job_ready_i;
  assign job_valid_o = in_valid_i;

  assign code     = in_data_i[7:0];
  assign origin_x = in_data_i[19:8];
  assign origin_y = in_data_i[31:20];
  assign color    = in_data_i[47:32];

  always_comb begin
    logic signed [ROW_Y_W-1:0] x;
    cur_x = in_first_i ? origin_x : cursor_x_q;
    cur_y = in_first_i ? origin_y : cursor_y_q;

    // clamp the register into 1..MAX_SCALE
    scale = {1'b0, scale_cfg_q};
    if (scale == '0) begin
      scale = SCALE_W'(1);
    end else if (scale > SCALE_W'(MAX_SCALE)) begin
      scale = SCALE_W'(MAX_SCALE);
    end

    for (int c = 0; c < MASK_W; c++) begin
      x = {cur_x[COORD_W-1], cur_x} + ROW_Y_W'(c);
      col_clip[c] = !x[ROW_Y_W-1] && (x < ROW_Y_W'(FRAME_WIDTH));
    end

    next_x = {cur_x[COORD_W-1], cur_x}
           + ROW_Y_W'(scale) * ROW_Y_W'(GLYPH_W + GLYPH_GAP);
    cursor_x_d = cursor_x_q;
    cursor_y_d = cursor_y_q;
    if (accept) begin
      cursor_y_d = cur_y;
      cursor_x_d = (next_x > $signed({1'b0, CURSOR_MAX})) ? CURSOR_MAX
                                                           : next_x[COORD_W-1:0];
    end
  end

  always_comb begin
    job_o.cursor_x    = cur_x;
    job_o.cursor_y    = cur_y;
    job_o.glyph       = glyph_rows(code);
    job_o.col_clip    = col_clip;
    job_o.panel_color = {color[7:0], color[15:8]};
    job_o.scale       = scale;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_cfg_q <= SCALE_RESET;
      cursor_x_q  <= '0;
      cursor_y_q  <= '0;
    end else begin
      if (cfg_valid_i) begin
        scale_cfg_q <= cfg_data_i;
      end
      cursor_x_q <= cursor_x_d;
      cursor_y_q <= cursor_y_d;
    end
  end

  a_first_loads_y: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_first_i |=> cursor_y_q == $past(origin_y))
    else $error("cursor y not loaded from origin on first character");

  a_x_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !in_first_i |=> cursor_x_q >= $past(cursor_x_q))
    else $error("cursor x moved backward without a string start");

endmodule

@@ src/srtr_queue.sv @@
// Short register queue between the front and back ends.
module srtr_queue import srtr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_valid_i,
  output logic       push_ready_o,
  input  glyph_job_t push_data_i,
  output logic       pop_valid_o,
  input  logic       pop_i,
  output glyph_job_t pop_data_o
);

  glyph_job_t        entries_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q;
  logic              push, pop;

  assign push_ready_o = count_q != QCNT_W'(QUEUE_DEPTH);
  assign pop_valid_o  = count_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_i && pop_valid_o;
  assign pop_data_o   = entries_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      count_q <= count_q + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> pop_valid_o)
    else $error("back end consumed from an empty queue");

endmodule

@@ src/srtr_back.sv @@
// Back end: walks the physical rows of the head character and registers one span a cycle unless stalled.
module srtr_back import srtr_pkg::*; #(
  parameter int FRAME_HEIGHT = 240,
  parameter int MAX_SCALE    = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  job_valid_i,
  output logic                  job_pop_o,
  input  glyph_job_t            job_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [OUT_DATA_W-1:0] out_data_o,
  output logic                  out_last_o
);

  localparam int ROW_W = $clog2(GLYPH_H * MAX_SCALE);

  logic [ROW_W-1:0]   row_q;
  logic [2:0]         frow_q;
  logic [SCALE_W-1:0] sub_q;

  logic                  out_valid_q;
  logic [OUT_DATA_W-1:0] out_data_q;
  logic                  out_last_q;

  logic                      advance, last_sub, last_span, row_ok;
  logic signed [ROW_Y_W-1:0] row_y;
  logic [MASK_W-1:0]         mask;

  function automatic logic [MASK_W-1:0] expand(input logic [GLYPH_W-1:0] bits,
                                               input logic [SCALE_W-1:0] sc);
    logic [MASK_W-1:0] m;
    m = '0;
    for (int s = 1; s <= MAX_SCALE; s++) begin
      if (sc == SCALE_W'(s)) begin
        for (int col = 0; col < GLYPH_W; col++) begin
          for (int k = 0; k < s; k++) begin
            if (col * s + k < MASK_W) begin
              m[col * s + k] = bits[GLYPH_W - 1 - col];
            end
          end
        end
      end
    end
    return m;
  endfunction

  assign advance   = job_valid_i && (!out_valid_q || out_ready_i);
  assign last_sub  = sub_q == job_i.scale - 1'b1;
  assign last_span = last_sub && (frow_q == LAST_FROW);
  assign job_pop_o = advance && last_span;

  always_comb begin
    row_y  = {job_i.cursor_y[COORD_W-1], job_i.cursor_y} + ROW_Y_W'(row_q);
    row_ok = !row_y[ROW_Y_W-1] && (row_y < ROW_Y_W'(FRAME_HEIGHT));
    mask   = expand(job_i.glyph[frow_q], job_i.scale) & job_i.col_clip
           & {MASK_W{row_ok}};
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= {3'b000, job_i.panel_color, mask, job_i.cursor_x, row_y};
      out_last_q <= last_span;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      row_q       <= '0;
      frow_q      <= '0;
      sub_q       <= '0;
    end else begin
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (advance) begin
        if (last_span) begin
          row_q  <= '0;
          frow_q <= '0;
          sub_q  <= '0;
        end else begin
          row_q <= row_q + 1'b1;
          if (last_sub) begin
            sub_q  <= '0;
            frow_q <= frow_q + 1'b1;
          end else begin
            sub_q <= sub_q + 1'b1;
          end
        end
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_last_o  = out_last_q;

  a_frow_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frow_q <= LAST_FROW)
    else $error("glyph row counter past the last font row");

  a_sub_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid_i |-> sub_q < job_i.scale)
    else $error("row repeat counter past the scale of the head character");

endmodule

@@ tb/scaled_5x7_text_renderer_top_tb.sv @@
// Self-checking testbench for the scaled 5x7 text renderer: stream stimulus and span checks.
module scaled_5x7_text_renderer_top_tb;
  import srtr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAME_W      = 536;
  localparam int FRAME_H      = 240;
  localparam int SCALE_LIMIT  = 4;
  localparam int CURSOR_TOP   = 2047;
  localparam int DRAIN_CYCLES = 8;
  localparam int LONG_HOLD    = 150;
  localparam int REPORT_LIMIT = 10;
  localparam int TIMEOUT_NS   = 4000000;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 22;

  localparam logic [15:0]      RX_PATTERN_BITS = 16'b1011_0011_1110_0101;
  localparam logic [CFG_W-1:0] SCALE_SEQ [PHASES] = '{3'd1, 3'd3, 3'd4, 3'd0,
                                                      3'd5, 3'd7, 3'd4, 3'd2};

  typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PATTERN, RX_COIN} rx_mode_e;

  // Tracks the text cursor and scale, and holds the row spans still owed by the block.
  class span_tracker;
    typedef struct packed {
      logic [ROW_Y_W-1:0] row_y;
      logic [COORD_W-1:0] span_x;
      logic [MASK_W-1:0]  pixel_mask;
      logic [COLOR_W-1:0] panel_color;
      logic               last_row;
    } span_t;

    int    scale_reg = int'(SCALE_RESET);
    int    cur_x;
    int    cur_y;
    int    fault_cnt;
    span_t owed_spans[$];

    function void set_scale(logic [CFG_W-1:0] value);
      scale_reg = int'(value);
    endfunction

    function int pending();
      return owed_spans.size();
    endfunction

    function int faults();
      return fault_cnt;
    endfunction

    function void note_char(logic [CODE_W-1:0] code, bit first_char,
                            logic signed [COORD_W-1:0] org_x,
                            logic signed [COORD_W-1:0] org_y,
                            logic [COLOR_W-1:0] color);
      int               eff;
      int               nrows;
      int               y;
      int               x;
      logic [CODE_W-1:0] key;
      logic [55:0]      rows;
      logic [4:0]       bits;
      logic [MASK_W-1:0] mask;
      span_t            s;
      eff = scale_reg;
      if (eff < 1) eff = 1;
      if (eff > SCALE_LIMIT) eff = SCALE_LIMIT;
      if (first_char) begin
        cur_x = org_x;
        cur_y = org_y;
      end
      key = code;
      if (code >= "a" && code <= "z") key = code - 8'h20;
      rows = glyph_of(key);
      nrows = GLYPH_H * eff;
      for (int r = 0; r < nrows; r++) begin
        y = cur_y + r;
        bits = rows[8 * (GLYPH_H - 1 - r / eff) +: 5];
        mask = '0;
        if (y >= 0 && y < FRAME_H) begin
          for (int c = 0; c < GLYPH_W * eff && c < MASK_W; c++) begin
            x = cur_x + c;
            if (x >= 0 && x < FRAME_W && bits[GLYPH_W - 1 - c / eff]) mask[c] = 1'b1;
          end
        end
        s.row_y       = ROW_Y_W'(y);
        s.span_x      = COORD_W'(cur_x);
        s.pixel_mask  = mask;
        s.panel_color = {color[7:0], color[15:8]};
        s.last_row    = (r == nrows - 1);
        owed_spans    = {owed_spans, s};
      end
      cur_x = cur_x + (GLYPH_W + GLYPH_GAP) * eff;
      if (cur_x > CURSOR_TOP) cur_x = CURSOR_TOP;
    endfunction

    function void check_span(logic [OUT_DATA_W-1:0] data, logic last_row);
      span_t got;
      span_t want;
      got.row_y       = data[12:0];
      got.span_x      = data[24:13];
      got.pixel_mask  = data[44:25];
      got.panel_color = data[60:45];
      got.last_row    = last_row;
      if (owed_spans.size() == 0) begin
        fault_cnt++;
        if (fault_cnt <= REPORT_LIMIT)
          $display("%0t: unexpected span y=%0d x=%0d mask=%05h color=%04h last=%0b",
                   $realtime, $signed(got.row_y), $signed(got.span_x), got.pixel_mask,
                   got.panel_color, got.last_row);
        return;
      end
      want = owed_spans.pop_front();
      if (got.row_y !== want.row_y || got.span_x !== want.span_x ||
          got.pixel_mask !== want.pixel_mask || got.panel_color !== want.panel_color ||
          got.last_row !== want.last_row || data[63:61] !== 3'b000) begin
        fault_cnt++;
        if (fault_cnt <= REPORT_LIMIT) begin
          $display("%0t: span mismatch", $realtime);
          $display("  exp y=%0d x=%0d mask=%05h color=%04h last=%0b",
                   $signed(want.row_y), $signed(want.span_x), want.pixel_mask,
                   want.panel_color, want.last_row);
          $display("  got y=%0d x=%0d mask=%05h color=%04h last=%0b pad=%0h",
                   $signed(got.row_y), $signed(got.span_x), got.pixel_mask,
                   got.panel_color, got.last_row, data[63:61]);
        end
      end
    endfunction

    // Font rows packed one byte per row, top row in the highest byte, bit 4 leftmost.
    function logic [55:0] glyph_of(logic [CODE_W-1:0] key);
      case (key)
        8'h21: return 56'h04040404040004;
        8'h22: return 56'h0A0A0A00000000;
        8'h23: return 56'h0A0A1F0A1F0A0A;
        8'h25: return 56'h19190204081313;
        8'h26: return 56'h0C12140815120D;
        8'h27: return 56'h04040800000000;
        8'h28: return 56'h02040808080402;
        8'h29: return 56'h08040202020408;
        8'h2A: return 56'h00150E1F0E1500;
        8'h2B: return 56'h0004041F040400;
        8'h2C: return 56'h00000000060408;
        8'h2D: return 56'h0000001F000000;
        8'h2E: return 56'h00000000000C0C;
        8'h2F: return 56'h01020204080810;
        8'h30: return 56'h0E11131519110E;
        8'h31: return 56'h040C040404040E;
        8'h32: return 56'h0E11010204081F;
        8'h33: return 56'h1E01010E01011E;
        8'h34: return 56'h02060A121F0202;
        8'h35: return 56'h1F10101E01011E;
        8'h36: return 56'h0E10101E11110E;
        8'h37: return 56'h1F010204080808;
        8'h38: return 56'h0E11110E11110E;
        8'h39: return 56'h0E11110F01010E;
        8'h3A: return 56'h000C0C000C0C00;
        8'h3B: return 56'h000C0C00060408;
        8'h3F: return 56'h0E110102040004;
        8'h3E: return 56'h10080402040810;
        8'h41: return 56'h0E11111F111111;
        8'h42: return 56'h1E11111E11111E;
        8'h43: return 56'h0E11101010110E;
        8'h44: return 56'h1E11111111111E;
        8'h45: return 56'h1F10101E10101F;
        8'h46: return 56'h1F10101E101010;
        8'h47: return 56'h0E11101711110F;
        8'h48: return 56'h1111111F111111;
        8'h49: return 56'h0E04040404040E;
        8'h4A: return 56'h0702020212120C;
        8'h4B: return 56'h11121418141211;
        8'h4C: return 56'h1010101010101F;
        8'h4D: return 56'h111B1515111111;
        8'h4E: return 56'h11191513111111;
        8'h4F: return 56'h0E11111111110E;
        8'h50: return 56'h1E11111E101010;
        8'h51: return 56'h0E11111115120D;
        8'h52: return 56'h1E11111E141211;
        8'h53: return 56'h0F10100E01011E;
        8'h54: return 56'h1F040404040404;
        8'h55: return 56'h1111111111110E;
        8'h56: return 56'h111111110A0A04;
        8'h57: return 56'h11111115151B11;
        8'h58: return 56'h110A0404040A11;
        8'h59: return 56'h110A0404040404;
        8'h5A: return 56'h1F01020408101F;
        8'h5F: return 56'h0000000000001F;
        default: return '0;
      endcase
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_W-1:0]      cfg_data;
  logic                  in_valid;
  logic                  in_ready;
  logic [IN_DATA_W-1:0]  in_data;
  logic                  in_user;
  logic                  out_valid;
  logic                  out_ready;
  logic [OUT_DATA_W-1:0] out_data;
  logic                  out_last;
  rx_mode_e              rx_mode;
  bit                    long_hold_req;
  span_tracker           sb;

  scaled_5x7_text_renderer_top #(
    .FRAME_WIDTH  (FRAME_W),
    .FRAME_HEIGHT (FRAME_H),
    .MAX_SCALE    (SCALE_LIMIT)
  ) u_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_data_i    (cfg_data),
    .s_axis_tvalid (in_valid),
    .s_axis_tready (in_ready),
    .s_axis_tdata  (in_data),
    .s_axis_tuser  (in_user),
    .m_axis_tvalid (out_valid),
    .m_axis_tready (out_ready),
    .m_axis_tdata  (out_data),
    .m_axis_tlast  (out_last)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Note every transaction on each channel at the rising edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.set_scale(cfg_data);
      if (in_valid && in_ready)
        sb.note_char(in_data[7:0], in_user, in_data[19:8], in_data[31:20], in_data[47:32]);
      if (out_valid && out_ready) sb.check_span(out_data, out_last);
    end
  end

  // Receiver: stall on its own pattern, plus one long hold on request.
  initial begin : rx_proc
    int rx_cycle;
    int hold_left;
    bit hold_done;
    rx_cycle  = 0;
    hold_left = 0;
    hold_done = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      rx_cycle++;
      if (long_hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        out_ready = 1'b0;
        hold_left--;
      end else begin
        case (rx_mode)
          RX_ALWAYS:  out_ready = 1'b1;
          RX_RANDOM:  out_ready = ($urandom_range(0, 3) != 0);
          RX_PATTERN: out_ready = RX_PATTERN_BITS[rx_cycle[3:0]];
          RX_COIN:    out_ready = 1'($urandom_range(0, 1));
          default:    out_ready = 1'b1;
        endcase
      end
    end
  end

  function automatic logic [CODE_W-1:0] pick_code();
    int sel;
    sel = $urandom_range(0, 19);
    if (sel < 10) return CODE_W'($urandom_range(32'h20, 32'h5F));
    else if (sel < 14) return CODE_W'($urandom_range(32'h61, 32'h7A));
    else return CODE_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [COORD_W-1:0] pick_x();
    int sel;
    int v;
    sel = $urandom_range(0, 9);
    case (sel)
      0:       v = -2048;
      1:       v = 2047 - int'($urandom_range(0, 10));
      2:       v = -int'($urandom_range(1, 40));
      3:       v = FRAME_W - int'($urandom_range(0, 30));
      default: v = int'($urandom_range(0, FRAME_W));
    endcase
    return COORD_W'(v);
  endfunction

  function automatic logic [COORD_W-1:0] pick_y();
    int sel;
    int v;
    sel = $urandom_range(0, 9);
    case (sel)
      0:       v = -2048;
      1:       v = 2047 - int'($urandom_range(0, 20));
      2:       v = -int'($urandom_range(1, 30));
      3:       v = FRAME_H - int'($urandom_range(0, 25));
      default: v = int'($urandom_range(0, FRAME_H));
    endcase
    return COORD_W'(v);
  endfunction

  // Offer one character and hold it until the transaction; return at a falling edge.
  task automatic send_char(input logic [CODE_W-1:0] code, input logic first_char,
                           input logic [COORD_W-1:0] org_x,
                           input logic [COORD_W-1:0] org_y,
                           input logic [COLOR_W-1:0] color);
    in_data  = {color, org_y, org_x, code};
    in_user  = first_char;
    in_valid = 1'b1;
    do begin
      @(posedge clk);
    end while (!in_ready);
    @(negedge clk);
  endtask

  task automatic idle(input int cycles);
    in_valid = 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  task automatic write_scale(input logic [CFG_W-1:0] value);
    cfg_data  = value;
    cfg_valid = 1'b1;
    do begin
      @(posedge clk);
    end while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic run_phase(input int count, input bit hold);
    int sent;
    int burst;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 6);
      for (int i = 0; i < burst && sent < count; i++) begin
        if (hold && sent == 4) long_hold_req = 1'b1;
        send_char(pick_code(), (sent == 0) || ($urandom_range(0, 5) == 0),
                  pick_x(), pick_y(), COLOR_W'($urandom()));
        sent++;
      end
      idle($urandom_range(0, 12));
    end
  endtask

  initial begin : main_proc
    sb            = new();
    rst_n         = 1'b0;
    cfg_valid     = 1'b0;
    cfg_data      = '0;
    in_valid      = 1'b0;
    in_data       = '0;
    in_user       = 1'b0;
    rx_mode       = RX_ALWAYS;
    long_hold_req = 1'b0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;
    repeat (2) @(negedge clk);

    // draw from the reset cursor before any string start
    send_char(8'h48, 1'b0, '0, '0, 16'h1234);
    send_char(8'h69, 1'b0, '0, '0, 16'hABCD);
    run_phase(28, 1'b0);
    wait_drained();

    for (int p = 0; p < PHASES; p++) begin
      write_scale(SCALE_SEQ[p]);
      rx_mode = rx_mode_e'(p % 4);
      run_phase(PHASE_ITEMS, p == 2);
      wait_drained();
    end

    if (sb.faults() == 0 && sb.pending() == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  initial begin : limit_proc
    #(TIMEOUT_NS);
    $display("simulation failed");
    $finish;
  end

endmodule
